### hdl/kmes_pkg.sv
// shared types and constants for the keypad matrix edge scanner
package kmes_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 3;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KEY_W  = 4;
  localparam int LVL_W  = 4;
  localparam int GRP_W  = 2;
  // queue depth, a power of two so the pointers wrap on their own
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [GRP_W-1:0] GROUP_BUTTON = '0;
  localparam logic [KEY_W-1:0] BUTTON_KEY   = KEY_W'(COLS * ROWS);

  typedef struct packed {
    logic [GRP_W-1:0] group;
    logic [LVL_W-1:0] levels;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_number;
    logic             released;
    logic             last_event;
  } out_word_t;

  // one queued job: events at the set rows of mask, upward from key_base,
  // the top one a release when rel is set
  typedef struct packed {
    logic [KEY_W-1:0] key_base;
    logic [ROWS-1:0]  mask;
    logic             rel;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

### hdl/kmes_front.sv
// front part: accepts sampled groups, compares against history, builds event jobs
module kmes_front import kmes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     q_full_i,
  output push_t    push_o
);

  logic [ROWS-1:0] col_hist_q [COLS];
  logic [ROWS-1:0] col_hist_d;
  logic            btn_hist_q;
  logic            accept;
  logic [2:0]      col_full;
  logic [COL_W-1:0] col_idx;
  logic            is_col;
  logic [ROWS-1:0] lv;
  logic [ROWS-1:0] hist;
  logic [ROWS-1:0] mask;
  logic            rel;
  logic            stop;
  logic [KEY_W-1:0] base;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign col_full   = {1'b0, in_word_i.group} - 3'd1;
  assign is_col     = (in_word_i.group != GROUP_BUTTON) && (int'(col_full) < COLS);
  assign col_idx    = col_full[COL_W-1:0];
  assign hist       = is_col ? col_hist_q[col_idx] : '1;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      lv[r] = (r < LVL_W) ? in_word_i.levels[r % LVL_W] : 1'b0;
    end
  end

  always_comb begin
    mask       = '0;
    rel        = 1'b0;
    stop       = 1'b0;
    col_hist_d = hist;
    base       = BUTTON_KEY;
    if (in_word_i.group == GROUP_BUTTON) begin
      if (btn_hist_q != in_word_i.levels[0]) begin
        mask = ROWS'(1);
      end
      rel = in_word_i.levels[0];
    end else if (is_col) begin
      base = KEY_W'(int'(col_full) * ROWS);
      for (int r = 0; r < ROWS; r++) begin
        if (!stop) begin
          if (!hist[r] && lv[r]) begin
            mask[r]       = 1'b1;
            rel           = 1'b1;
            col_hist_d[r] = 1'b1;
            stop          = 1'b1;
          end else if (hist[r] && !lv[r]) begin
            mask[r]       = 1'b1;
            col_hist_d[r] = 1'b0;
          end
        end
      end
    end
  end

  assign push_o.push         = accept && (|mask);
  assign push_o.job.key_base = base;
  assign push_o.job.mask     = mask;
  assign push_o.job.rel      = rel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_hist_q <= 1'b1;
      for (int c = 0; c < COLS; c++) begin
        col_hist_q[c] <= '1;
      end
    end else if (accept) begin
      if (in_word_i.group == GROUP_BUTTON) begin
        btn_hist_q <= in_word_i.levels[0];
      end else if (is_col) begin
        col_hist_q[col_idx] <= col_hist_d;
      end
    end
  end

endmodule

### hdl/kmes_queue.sv
// short job queue between the front and back parts
module kmes_queue import kmes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output job_t  head_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hdl/kmes_back.sv
// back part: walks each job row by row, emits one event word per unstalled cycle
module kmes_back import kmes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  job_t             cur_q;
  job_t             act;
  logic             cur_busy;
  logic             act_valid;
  logic             advance;
  logic [ROW_W-1:0] idx;
  logic [ROWS-1:0]  rest;
  logic             last;
  logic             out_valid_q;
  out_word_t        out_q;

  assign cur_busy  = |cur_q.mask;
  assign act       = cur_busy ? cur_q : head_i;
  assign act_valid = cur_busy || !empty_i;
  assign advance   = act_valid && (!out_valid_q || !out_stall_i);
  assign pop_o     = advance && !cur_busy;

  always_comb begin
    idx = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (act.mask[r]) begin
        idx = ROW_W'(r);
      end
    end
  end

  assign rest = act.mask & ~(ROWS'(1) << idx);
  assign last = (rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        cur_q.mask     <= rest;
        cur_q.key_base <= act.key_base;
        cur_q.rel      <= act.rel;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.key_number <= act.key_base + KEY_W'(idx);
      out_q.released   <= act.rel && last;
      out_q.last_event <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### hdl/keypad_matrix_edge_scanner_top.sv
// keypad matrix edge scanner top level
// Takes one sampled group word per cycle while in_stall_o is low (the button,
// or one keypad column) and turns level changes against the stored history
// into press and release event words. The front part classifies a word in the
// cycle it is accepted and updates the history at once, so words can follow
// back to back; a two-entry job queue feeds the back part, which sends one
// event word per cycle while out_stall_i is low, from a registered output, so
// a word with k events yields k event words (one to four, none for a word with
// no change). Input stall is raised only while the job queue is full.
module keypad_matrix_edge_scanner_top import kmes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  push_t push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  job_t  q_head;

  kmes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  kmes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  kmes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### verif/kmes_event_checker.sv
// event checker for the keypad matrix edge scanner: predicts event words and compares them
module kmes_event_checker import kmes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  logic [ROWS-1:0] column_levels [COLS];
  logic            button_level = 1'b1;
  out_word_t       expected_events [$];
  out_word_t       want;

  initial begin
    for (int c = 0; c < COLS; c++) column_levels[c] = '1;
    error_count_o = 0;
    pending_o = 0;
  end

  function automatic out_word_t make_event(logic [KEY_W-1:0] key, logic rel);
    out_word_t ev;
    ev.key_number = key;
    ev.released   = rel;
    ev.last_event = 1'b0;
    return ev;
  endfunction

  // updates the key history and queues the events caused by one group word
  function automatic void predict_events(in_word_t w);
    out_word_t       evs [$];
    out_word_t       ev;
    logic [ROWS-1:0] lvl;
    int              col;
    bit              done;
    if (w.group == GROUP_BUTTON) begin
      if (button_level != w.levels[0]) begin
        evs.push_back(make_event(BUTTON_KEY, w.levels[0] ? EV_RELEASE : EV_PRESS));
      end
      button_level = w.levels[0];
    end else if (int'(w.group) <= COLS) begin
      col  = int'(w.group) - 1;
      lvl  = ROWS'(w.levels);
      done = 1'b0;
      for (int r = 0; r < ROWS && !done; r++) begin
        if (!column_levels[col][r] && lvl[r]) begin
          evs.push_back(make_event(KEY_W'(col * ROWS + r), EV_RELEASE));
          column_levels[col][r] = 1'b1;
          done = 1'b1;
        end else if (column_levels[col][r] && !lvl[r]) begin
          evs.push_back(make_event(KEY_W'(col * ROWS + r), EV_PRESS));
          column_levels[col][r] = 1'b0;
        end
      end
    end
    for (int i = 0; i < evs.size(); i++) begin
      ev = evs[i];
      ev.last_event = (i == evs.size() - 1);
      expected_events.push_back(ev);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLS; c++) column_levels[c] = '1;
      button_level = 1'b1;
      expected_events.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event word, expected none, actual key %0d released %0b last %0b",
                   $time, out_word_i.key_number, out_word_i.released, out_word_i.last_event);
          error_count_o++;
        end else begin
          want = expected_events.pop_front();
          if (out_word_i.key_number !== want.key_number) begin
            $display("%0t: key_number expected %0d actual %0d",
                     $time, want.key_number, out_word_i.key_number);
            error_count_o++;
          end
          if (out_word_i.released !== want.released) begin
            $display("%0t: released expected %0b actual %0b",
                     $time, want.released, out_word_i.released);
            error_count_o++;
          end
          if (out_word_i.last_event !== want.last_event) begin
            $display("%0t: last_event expected %0b actual %0b",
                     $time, want.last_event, out_word_i.last_event);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_events(in_word_i);
    end
    pending_o = expected_events.size();
  end

endmodule

### verif/testbench.sv
// testbench top for the keypad matrix edge scanner: stimulus, receiver stalls and verdict
module testbench import kmes_pkg::*;;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 120;
  localparam int RANDOM_WORDS   = 500;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  localparam logic [GRP_W-1:0] GROUP_COL0 = 2'd1;
  localparam logic [GRP_W-1:0] GROUP_COL1 = 2'd2;
  localparam logic [GRP_W-1:0] GROUP_COL2 = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  int unsigned error_count;
  int unsigned pending_events;

  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          start_hold = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  keypad_matrix_edge_scanner_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  kmes_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .error_count_o (error_count),
    .pending_o     (pending_events)
  );

  task automatic send_word(input logic [GRP_W-1:0] grp, input logic [LVL_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word.group <= grp;
    in_word.levels <= lvl;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  initial begin
    logic [LVL_W-1:0] lvl;
    int               pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // button press, repeat, ignored upper bits, release
    send_word(GROUP_BUTTON, 4'b0000);
    send_word(GROUP_BUTTON, 4'b0000);
    send_word(GROUP_BUTTON, 4'b1110);
    send_word(GROUP_BUTTON, 4'b1111);
    send_word(GROUP_BUTTON, 4'b0001);
    // all rows pressed, then releases one row per word
    send_word(GROUP_COL0, 4'b0000);
    send_word(GROUP_COL0, 4'b1111);
    send_word(GROUP_COL0, 4'b1111);
    send_word(GROUP_COL0, 4'b1111);
    send_word(GROUP_COL0, 4'b1111);
    send_word(GROUP_COL0, 4'b1111);
    // press below a release in the same word
    send_word(GROUP_COL1, 4'b0101);
    send_word(GROUP_COL1, 4'b1010);
    send_word(GROUP_COL1, 4'b1111);
    send_word(GROUP_COL1, 4'b1111);
    send_word(GROUP_COL2, 4'b0000);
    send_word(GROUP_COL2, 4'b0111);
    send_word(GROUP_COL2, 4'b1111);
    send_word(GROUP_COL2, 4'b1111);
    send_word(GROUP_COL2, 4'b1000);
    send_word(GROUP_COL2, 4'b1111);

    start_hold = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        lvl = LVL_W'($urandom_range(0, 15));
      end else if (pick < 7) begin
        lvl = 4'b1111;
      end else begin
        lvl = ~(LVL_W'(1) << $urandom_range(0, LVL_W - 1));
      end
      send_word(GRP_W'($urandom_range(0, 3)), lvl);
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending_events != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_events == 0) begin
      $display("keypad_matrix_edge_scanner_top verification clean");
    end else begin
      $display("keypad_matrix_edge_scanner_top verification failed");
    end
    $finish;
  end

  // receiver stalls, with one long hold-off once random traffic starts
  initial begin
    int          mode;
    int          left;
    int unsigned phase;
    bit          hold_done;
    mode = STALL_NONE;
    left = 0;
    phase = 0;
    hold_done = 1'b0;
    forever begin
      if (start_hold && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
          left = $urandom_range(10, 60);
        end
        left--;
        phase++;
        case (mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          STALL_HEAVY: begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
          default: begin
            out_stall <= ((phase % 5) < 2);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("keypad_matrix_edge_scanner_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
hdl/kmes_pkg.sv
hdl/kmes_front.sv
hdl/kmes_queue.sv
hdl/kmes_back.sv
hdl/keypad_matrix_edge_scanner_top.sv
verif/kmes_event_checker.sv
verif/testbench.sv
